[hdl/fsib_pkg.sv]
// Shared types and constants for the frequency-sorted index builder.
// Depends on nothing; every other file of the block imports it.
package fsib_pkg;

  // Number of entries the index holds, one cell each.
  localparam int ENTRIES      = 256;
  // Byte offset step between consecutive logged records.
  localparam int RECORD_BYTES = 16;

  localparam int KEY_W = 32;
  localparam int OFF_W = 32;

  // Item kind codes on the input channel.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // One stored entry as it moves along the chain.
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [OFF_W-1:0] off;
  } entry_t;

  // Operation broadcast to every cell in a cycle.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_POP,
    OP_CLEAR
  } op_t;

  // Command bundle sent from the top level to the cells.
  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] freq;
    logic [OFF_W-1:0] off;
  } cmd_t;

endpackage

[hdl/fsib_cell.sv]
// One cell of the sorted chain: holds a single entry and trades it with its neighbors.
// Depends on fsib_pkg for the entry and command types.
module fsib_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  fsib_pkg::cmd_t   cmd_i,
  input  fsib_pkg::entry_t left_i,
  input  logic           left_take_i,
  input  fsib_pkg::entry_t right_i,
  output fsib_pkg::entry_t ent_o,
  output logic           take_o
);
  import fsib_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;
  entry_t new_ent;
  logic   gt;

  // A cell gives way to a new key if it is empty or holds a strictly larger key.
  // Because the chain is sorted, the cells that give way form a suffix.
  always_comb begin
    gt      = ent_r.vld && (ent_r.key > cmd_i.freq);
    take_o  = gt || !ent_r.vld;
    new_ent = '{vld: 1'b1, key: cmd_i.freq, off: cmd_i.off};
    ent_nxt = ent_r;
    unique case (cmd_i.op)
      OP_INSERT: begin
        // The first cell that gives way stores the new entry; the rest shift right.
        if (take_o) begin
          ent_nxt = left_take_i ? left_i : new_ent;
        end
      end
      OP_POP: begin
        // Every cell takes its right neighbor's entry.
        ent_nxt = right_i;
      end
      OP_CLEAR: begin
        ent_nxt.vld = 1'b0;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // The valid bit is control state and is reset; key and offset carry no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
    ent_r.key <= ent_nxt.key;
    ent_r.off <= ent_nxt.off;
  end

  assign ent_o = ent_r;

endmodule

[hdl/frequency_sorted_index_builder_top.sv]
// Top level of the frequency-sorted index builder: command decode, offset counter, output register.
// Depends on fsib_pkg and fsib_cell.
//
// The index is a row of ENTRIES cells, kept in ascending frequency order with equal
// frequencies in arrival order. An insert, read or clear item is applied to all cells at
// once, with entries shifting one cell right (insert) or left (read). Items are accepted
// back to back, one per cycle; the only thing that holds the input is the single output
// register, which stalls the input while a read result is still waiting to be taken.
// Insert and clear items give no result; a read item gives exactly one. An insert into
// a full index is dropped but still advances the byte offset, which wraps at 32 bits.
// There is no clearing pass after reset.
module frequency_sorted_index_builder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [fsib_pkg::KEY_W-1:0]  in_frequency_hz,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fsib_pkg::KEY_W-1:0]  out_frequency_hz,
  output logic [fsib_pkg::OFF_W-1:0]  out_file_offset,
  output logic                        out_empty_res,
  output logic                        out_last
);
  import fsib_pkg::*;

  logic             in_fire;
  logic             full;
  cmd_t             cmd;
  logic [OFF_W-1:0] byte_off_r;
  logic [OFF_W-1:0] byte_off_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [KEY_W-1:0] out_freq_r;
  logic [OFF_W-1:0] out_off_r;
  logic             out_empty_r;
  logic             out_last_r;

  entry_t ents [ENTRIES];
  logic   takes [ENTRIES];

  // The input waits only while a read result is still held in the output register.
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign full     = ents[ENTRIES-1].vld;

  // Decode the accepted item into the command broadcast to the cells.
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.freq     = in_frequency_hz;
    cmd.off      = byte_off_r;
    byte_off_nxt = byte_off_r;
    if (in_fire) begin
      unique case (in_kind)
        KIND_INSERT: begin
          if (!full) begin
            cmd.op = OP_INSERT;
          end
          byte_off_nxt = byte_off_r + OFF_W'(RECORD_BYTES);
        end
        KIND_READ: begin
          if (ents[0].vld) begin
            cmd.op = OP_POP;
          end
        end
        KIND_CLEAR: begin
          cmd.op       = OP_CLEAR;
          byte_off_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // The chain of cells; the ends see a neutral left entry and an empty right entry.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_take;

    if (i == 0) begin : g_first
      assign left_ent  = '{vld: 1'b0, key: '0, off: '0};
      assign left_take = 1'b0;
    end else begin : g_mid
      assign left_ent  = ents[i-1];
      assign left_take = takes[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign right_ent = '{vld: 1'b0, key: '0, off: '0};
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    fsib_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd_i       (cmd),
      .left_i      (left_ent),
      .left_take_i (left_take),
      .right_i     (right_ent),
      .ent_o       (ents[i]),
      .take_o      (takes[i])
    );
  end

  // Output valid is set by an accepted read item and dropped once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && (in_kind == KIND_READ)) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state: output valid and the byte offset counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      byte_off_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      byte_off_r  <= byte_off_nxt;
    end
  end

  // Result payload, captured when a read item is accepted: the head cell's entry, or an empty result.
  always_ff @(posedge clk) begin
    if (in_fire && (in_kind == KIND_READ)) begin
      if (ents[0].vld) begin
        out_freq_r  <= ents[0].key;
        out_off_r   <= ents[0].off;
        out_empty_r <= 1'b0;
        out_last_r  <= !ents[1].vld;
      end else begin
        out_freq_r  <= '0;
        out_off_r   <= '0;
        out_empty_r <= 1'b1;
        out_last_r  <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frequency_hz = out_freq_r;
  assign out_file_offset  = out_off_r;
  assign out_empty_res    = out_empty_r;
  assign out_last         = out_last_r;

endmodule
